// ===== rtl/lkse_pkg.sv =====
// Package for the LED/keypad serial command encoder.
// Holds command bytes, mode and kind codes, item types and the key bit table.
// No dependencies.
package lkse_pkg;

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_KEYS  = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam logic KIND_WIRE = 1'b0;
  localparam logic KIND_KEY  = 1'b1;

  localparam logic [7:0] CMD_DISPLAY_CTRL = 8'h88;
  localparam logic [7:0] CMD_AUTO_INC     = 8'h40;
  localparam logic [7:0] CMD_FIXED_ADDR   = 8'h44;
  localparam logic [7:0] CMD_READ_KEYS    = 8'h42;
  localparam logic [7:0] CMD_ADDR_BASE    = 8'hC0;

  localparam logic [2:0] BRIGHTNESS_RST = 3'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] address;
    logic [7:0] data;
    logic [6:0] key_code;
  } hold_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] wire_byte;
    logic       frame_end;
    logic [6:0] key_code;
    logic       last;
  } result_t;

  function automatic logic [3:0] key_num(input logic [7:0] v);
    logic [3:0] n;
    case (v)
      8'h01:   n = 4'd1;
      8'h10:   n = 4'd2;
      8'h02:   n = 4'd3;
      8'h20:   n = 4'd4;
      8'h04:   n = 4'd5;
      8'h40:   n = 4'd6;
      8'h08:   n = 4'd7;
      8'h80:   n = 4'd8;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/led_keypad_serial_command_encoder_unit.sv =====
// Top level of the LED/keypad serial command encoder.
// The request is registered in the hold register and its first result in the result register.
// Throughput: one result per cycle while out_stall is low; init gives DISPLAY_BYTES+3 results,
// write 3, key read 2; the next request loads while the last result drains.
// Reset (rst_n, synchronous): request and result registers empty, brightness 2.
// Depends on lkse_pkg, lkse_keydec, lkse_seq.
module led_keypad_serial_command_encoder_unit import lkse_pkg::*; #(
  parameter int DISPLAY_BYTES = 16,
  parameter int SCAN_BYTES    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_brightness,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_address,
  input  logic [7:0]  in_data,
  input  logic [31:0] in_scan_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_wire_byte,
  output logic        out_frame_end,
  output logic [6:0]  out_key_code,
  output logic        out_last
);

  localparam int STEP_W = $clog2(DISPLAY_BYTES + 3);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DISPLAY_BYTES + 2);

  logic [2:0]        brightness_r;
  logic              hold_vld_r, hold_vld_nxt;
  hold_t             hold_r, hold_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_vld_r, out_vld_nxt;
  result_t           res_r, res_nxt;
  result_t           res;
  logic [6:0]        in_key;
  logic              in_xfer, load;

  lkse_keydec #(.SCAN_BYTES(SCAN_BYTES)) u_keydec (
    .scan_bytes (in_scan_bytes),
    .key_code   (in_key)
  );

  lkse_seq #(.DISPLAY_BYTES(DISPLAY_BYTES), .STEP_W(STEP_W)) u_seq (
    .hold       (hold_r),
    .step       (step_r),
    .brightness (brightness_r),
    .res        (res)
  );

  assign load     = hold_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = hold_vld_r && !(load && res.last);
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    hold_nxt     = hold_r;
    step_nxt     = step_r;
    if (load) begin
      if (res.last) begin
        hold_vld_nxt = 1'b0;
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
    if (in_xfer) begin
      hold_vld_nxt      = (in_mode != MODE_RSVD);
      hold_nxt.mode     = in_mode;
      hold_nxt.address  = in_address;
      hold_nxt.data     = in_data;
      hold_nxt.key_code = in_key;
      step_nxt          = '0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    res_nxt     = res_r;
    if (load) begin
      out_vld_nxt = 1'b1;
      res_nxt     = res;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHTNESS_RST;
      hold_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
      step_r       <= '0;
    end else begin
      if (cfg_we) begin
        brightness_r <= cfg_brightness;
      end
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      step_r     <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_kind      = res_r.kind;
  assign out_wire_byte = res_r.wire_byte;
  assign out_frame_end = res_r.frame_end;
  assign out_key_code  = res_r.key_code;
  assign out_last      = res_r.last;

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_vld_r |-> !in_stall)
    else $error("input stalled with no request held");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> step_r <= LAST_STEP)
    else $error("step counter beyond last result");

  a_key_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_KEY) |-> (out_last && out_frame_end))
    else $error("key result does not close the request");

  a_rsvd_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_mode == MODE_RSVD) |=> !hold_vld_r)
    else $error("reserved mode request was held");

endmodule

// ===== rtl/lkse_keydec.sv =====
// Key scan decoder: maps each single-bit scan byte to its key number and sums them.
// Depends on lkse_pkg.
module lkse_keydec import lkse_pkg::*; #(
  parameter int SCAN_BYTES = 4
) (
  input  logic [31:0] scan_bytes,
  output logic [6:0]  key_code
);

  logic [6:0] sum;
  logic [3:0] n;

  always_comb begin
    sum = '0;
    n   = '0;
    for (int j = 0; j < SCAN_BYTES; j++) begin
      n = key_num(scan_bytes[8*j +: 8]);
      if (n != 4'd0) begin
        sum = sum + (7'(j) << 3) + 7'(n);
      end
    end
  end

  assign key_code = sum;

endmodule

// ===== rtl/lkse_seq.sv =====
// Result generator: forms the result for one step of the held request.
// Depends on lkse_pkg.
module lkse_seq import lkse_pkg::*; #(
  parameter int DISPLAY_BYTES = 16,
  parameter int STEP_W        = 5
) (
  input  hold_t             hold,
  input  logic [STEP_W-1:0] step,
  input  logic [2:0]        brightness,
  output result_t           res
);

  localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(DISPLAY_BYTES + 2);

  always_comb begin
    res           = '0;
    res.kind      = KIND_WIRE;
    case (hold.mode)
      MODE_INIT: begin
        case (step)
          STEP_W'(0): begin
            res.wire_byte = CMD_DISPLAY_CTRL | {5'd0, brightness};
            res.frame_end = 1'b1;
          end
          STEP_W'(1): begin
            res.wire_byte = CMD_AUTO_INC;
            res.frame_end = 1'b1;
          end
          STEP_W'(2): begin
            res.wire_byte = CMD_ADDR_BASE;
          end
          default: begin
            res.wire_byte = 8'd0;
            res.frame_end = (step == INIT_LAST);
            res.last      = (step == INIT_LAST);
          end
        endcase
      end
      MODE_WRITE: begin
        case (step)
          STEP_W'(0): begin
            res.wire_byte = CMD_FIXED_ADDR;
            res.frame_end = 1'b1;
          end
          STEP_W'(1): begin
            res.wire_byte = CMD_ADDR_BASE | {4'd0, hold.address};
          end
          default: begin
            res.wire_byte = hold.data;
            res.frame_end = 1'b1;
            res.last      = 1'b1;
          end
        endcase
      end
      MODE_KEYS: begin
        if (step == STEP_W'(0)) begin
          res.wire_byte = CMD_READ_KEYS;
        end else begin
          res.kind      = KIND_KEY;
          res.key_code  = hold.key_code;
          res.frame_end = 1'b1;
          res.last      = 1'b1;
        end
      end
      default: begin
        res.last = 1'b1;
      end
    endcase
  end

endmodule
